@@ hdl/gsj_pkg.sv @@
// Package for the Gauss-Seidel / Jacobi solver: types, constants, fixed-point helpers.
// No dependencies; used by every module of the solver.
package gsj_pkg;

    localparam int MAX_EQ      = 8;
    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NCOLS       = MAX_EQ + 1;
    localparam int MEM_DEPTH   = MAX_EQ * NCOLS;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int IDX_W       = $clog2(MAX_EQ);
    localparam int CNT_W       = $clog2(MAX_EQ + 1);
    localparam int COL_W       = $clog2(NCOLS + 1);
    localparam int QDIV_W      = VALUE_WIDTH + FRAC_BITS;

    localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        REQ_LOAD_ENTRY = 2'd0,
        REQ_LOAD_GUESS = 2'd1,
        REQ_NORMALIZE  = 2'd2,
        REQ_ITERATE    = 2'd3
    } req_t;

    typedef struct packed {
        logic [1:0]                    req_type;
        logic [2:0]                    row;
        logic [3:0]                    col;
        logic signed [VALUE_WIDTH-1:0] value;
    } req_beat_t;

    typedef struct packed {
        logic                          status;
        logic [2:0]                    var_index;
        logic signed [VALUE_WIDTH-1:0] gs_value;
        logic signed [VALUE_WIDTH-1:0] gs_change;
        logic signed [VALUE_WIDTH-1:0] jacobi_value;
        logic signed [VALUE_WIDTH-1:0] jacobi_change;
        logic                          last;
    } res_beat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_NRM_SCAN_RD,
        ST_NRM_SCAN_CHK,
        ST_NRM_SWAP_RDI,
        ST_NRM_SWAP_RDJ,
        ST_NRM_SWAP_WRI,
        ST_NRM_SWAP_WRJ,
        ST_NRM_PIV_RD,
        ST_NRM_PIV_LATCH,
        ST_NRM_DIV_RD,
        ST_NRM_DIV_START,
        ST_NRM_DIV_WAIT,
        ST_NRM_DIV_WR,
        ST_NRM_DONE,
        ST_NRM_FAIL,
        ST_IT_RHS_RD,
        ST_IT_RHS_LATCH,
        ST_IT_A_RD,
        ST_IT_MUL,
        ST_IT_ACC,
        ST_IT_ROW_END,
        ST_IT_EMIT
    } state_t;

    // Divider control between sequencer and divide unit
    typedef struct packed {
        logic                          start;
        logic signed [VALUE_WIDTH-1:0] num;
        logic signed [VALUE_WIDTH-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                          done;
        logic signed [VALUE_WIDTH-1:0] quot;
    } div_rsp_t;

    // Saturating subtract a - b
    function automatic logic signed [VALUE_WIDTH-1:0] sat_sub(
        input logic signed [VALUE_WIDTH-1:0] a,
        input logic signed [VALUE_WIDTH-1:0] b
    );
        logic signed [VALUE_WIDTH:0] d;
        d = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
        if (d[VALUE_WIDTH] != d[VALUE_WIDTH-1])
            return d[VALUE_WIDTH] ? VMIN : VMAX;
        return d[VALUE_WIDTH-1:0];
    endfunction

    // Magnitude of a signed value, unsigned and of the same width, which holds VMIN's magnitude
    function automatic logic [VALUE_WIDTH-1:0] magn(
        input logic signed [VALUE_WIDTH-1:0] a
    );
        return a[VALUE_WIDTH-1] ? (~a + 1'b1) : a;
    endfunction

    // Apply sign to a magnitude and saturate to the value range
    function automatic logic signed [VALUE_WIDTH-1:0] sat_sign(
        input logic [2*VALUE_WIDTH-1:0] m,
        input logic                     neg
    );
        logic [2*VALUE_WIDTH-1:0] lim;
        lim = neg ? {{VALUE_WIDTH{1'b0}}, VMIN} : {{VALUE_WIDTH{1'b0}}, VMAX};
        if (m > lim)
            return neg ? VMIN : VMAX;
        return neg ? (~m[VALUE_WIDTH-1:0] + 1'b1) : m[VALUE_WIDTH-1:0];
    endfunction

endpackage

@@ hdl/gsj_div.sv @@
// Radix-2 restoring divider for signed fixed-point quotient a/d with saturation.
// Depends on gsj_pkg.
module gsj_div
    import gsj_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEP_W = $clog2(QDIV_W + 1);

    logic [QDIV_W-1:0]      num_reg, num_next;
    logic [QDIV_W-1:0]      quo_reg, quo_next;
    logic [VALUE_WIDTH:0]   rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] den_reg, den_next;
    logic                   neg_reg, neg_next;
    logic [STEP_W-1:0]      cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [VALUE_WIDTH:0]   shifted;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
    end

    // one quotient bit per cycle
    always_comb
    begin
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[VALUE_WIDTH-1:0], num_reg[QDIV_W-1]};
        if (req.start)
        begin
            num_next  = {magn(req.num), {FRAC_BITS{1'b0}}};
            den_next  = magn(req.den);
            neg_next  = req.num[VALUE_WIDTH-1] ^ req.den[VALUE_WIDTH-1];
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = STEP_W'(QDIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = num_reg << 1;
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = shifted - {1'b0, den_reg};
                quo_next = {quo_reg[QDIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[QDIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = sat_sign({{(2*VALUE_WIDTH-QDIV_W){1'b0}}, quo_reg}, neg_reg);

endmodule

@@ hdl/gsj_mul.sv @@
// Registered signed fixed-point multiplier with truncation and saturation.
// Depends on gsj_pkg.
module gsj_mul
    import gsj_pkg::*;
(
    input  logic                          clk,
    input  logic signed [VALUE_WIDTH-1:0] a,
    input  logic signed [VALUE_WIDTH-1:0] b,
    output logic signed [VALUE_WIDTH-1:0] p
);

    logic [2*VALUE_WIDTH-1:0] prod_reg;
    logic                     neg_reg;

    // magnitude product, registered
    always_ff @(posedge clk)
    begin
        prod_reg <= magn(a) * magn(b);
        neg_reg  <= a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
    end

    assign p = sat_sign(prod_reg >> FRAC_BITS, neg_reg);

endmodule

@@ hdl/gauss_seidel_jacobi_solver_unit.sv @@
// Gauss-Seidel / Jacobi solver top level: APB register, matrix store, sequencer.
// Depends on gsj_pkg, gsj_mul, gsj_div.
//
// Loads finish at the accepting edge: busy never rises, so another beat can be
// accepted on the next cycle. In iterate each row starts with a right-hand-side
// read and latch, then per multiply-accumulate step an address, coefficient, two
// multiplier phases and accumulate (none for n = 1) through one shared multiplier
// and one matrix read port, then a commit state. After that come result beats for
// the n variables, one per cycle; each beat shows on done in the cycle after its
// emit cycle, so the last one falls in the first idle cycle. Normalize divides each
// matrix column of a row by the row pivot (one quotient bit per cycle in the shared
// divider), after a pivot search and any row swap for that row.
// busy is high throughout; results appear for one cycle on done and cannot be
// stalled by the receiver.
module gauss_seidel_jacobi_solver_unit
    import gsj_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    input  req_beat_t   req,
    output logic        busy,
    output logic        done,
    output res_beat_t   res
);

    // matrix memory
    logic signed [VALUE_WIDTH-1:0] mem [MEM_DEPTH];
    logic [ADDR_W-1:0]             rd_addr, wr_addr;
    logic                          wr_en;
    logic signed [VALUE_WIDTH-1:0] wr_data;
    logic signed [VALUE_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // estimate vectors (fixed-place registers, small)
    logic signed [VALUE_WIDTH-1:0] gs_est_reg  [MAX_EQ];
    logic signed [VALUE_WIDTH-1:0] gs_prev_reg [MAX_EQ];
    logic signed [VALUE_WIDTH-1:0] jc_est_reg  [MAX_EQ];
    logic signed [VALUE_WIDTH-1:0] jc_next_reg [MAX_EQ];

    // configuration
    logic [CNT_W-1:0] eq_count_reg;
    logic [3:0]       wval;

    assign pready = 1'b1;
    assign wval   = pwdata[3:0];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eq_count_reg <= CNT_W'(MAX_EQ);
        else if (psel && penable && pwrite && paddr == 2'd0)
        begin
            if (wval == 4'd0)
                eq_count_reg <= CNT_W'(1);
            else if (wval > 4'(MAX_EQ))
                eq_count_reg <= CNT_W'(MAX_EQ);
            else
                eq_count_reg <= wval[CNT_W-1:0];
        end
    end
    assign prdata = (paddr == 2'd0) ? {{(32-CNT_W){1'b0}}, eq_count_reg} : 32'd0;

    // shared units
    logic signed [VALUE_WIDTH-1:0] mul_a, mul_b, mul_p;
    div_req_t dreq;
    div_rsp_t drsp;

    gsj_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));
    gsj_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // sequencer state
    state_t state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [COL_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic signed [VALUE_WIDTH-1:0] t_reg, t_next;   // swap temp / pivot
    logic signed [VALUE_WIDTH-1:0] a_reg, a_next;   // coefficient
    logic signed [VALUE_WIDTH-1:0] g_reg, g_next;   // Gauss-Seidel accumulator
    logic signed [VALUE_WIDTH-1:0] jn_reg, jn_next; // Jacobi accumulator
    logic                          ph_reg, ph_next; // multiplier phase
    logic                          done_reg, done_next;
    res_beat_t                     res_reg, res_next;

    function automatic logic [ADDR_W-1:0] addr_of(
        input logic [IDX_W-1:0] r,
        input logic [COL_W-1:0] c
    );
        return ADDR_W'(r * NCOLS + c);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        j_reg   <= j_next;
        k_reg   <= k_next;
        n_reg   <= n_next;
        t_reg   <= t_next;
        a_reg   <= a_next;
        g_reg   <= g_next;
        jn_reg  <= jn_next;
        ph_reg  <= ph_next;
        res_reg <= res_next;
    end

    // estimate vector updates
    logic                          ld_guess;
    logic                          gs_wr, jn_wr, emit_wr;
    always_ff @(posedge clk)
    begin
        if (ld_guess)
        begin
            gs_est_reg[req.row[IDX_W-1:0]]  <= req.value;
            gs_prev_reg[req.row[IDX_W-1:0]] <= req.value;
            jc_est_reg[req.row[IDX_W-1:0]]  <= req.value;
        end
        if (gs_wr)
            gs_est_reg[i_reg] <= g_reg;
        if (jn_wr)
            jc_next_reg[i_reg] <= jn_reg;
        if (emit_wr)
        begin
            gs_prev_reg[i_reg] <= gs_est_reg[i_reg];
            jc_est_reg[i_reg]  <= jc_next_reg[i_reg];
        end
    end

    logic [IDX_W-1:0] n_last;
    assign n_last = IDX_W'(n_reg - 1'b1);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        t_next     = t_reg;
        a_next     = a_reg;
        g_next     = g_reg;
        jn_next    = jn_reg;
        ph_next    = ph_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        rd_addr    = addr_of(i_reg, k_reg);
        wr_addr    = addr_of(i_reg, k_reg);
        wr_en      = 1'b0;
        wr_data    = rd_data_reg;
        ld_guess   = 1'b0;
        gs_wr      = 1'b0;
        jn_wr      = 1'b0;
        emit_wr    = 1'b0;
        dreq.start = 1'b0;
        dreq.num   = rd_data_reg;
        dreq.den   = t_reg;
        mul_a      = a_reg;
        mul_b      = ph_reg ? jc_est_reg[j_reg] : gs_est_reg[j_reg];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    n_next = eq_count_reg;
                    i_next = '0;
                    unique case (req_t'(req.req_type))
                        REQ_LOAD_ENTRY:
                        begin
                            wr_addr = addr_of(req.row[IDX_W-1:0], COL_W'(req.col));
                            wr_data = req.value;
                            wr_en   = (req.col <= 4'(MAX_EQ));
                        end
                        REQ_LOAD_GUESS:
                            ld_guess = 1'b1;
                        REQ_NORMALIZE:
                        begin
                            j_next     = '0;
                            state_next = ST_NRM_SCAN_RD;
                        end
                        REQ_ITERATE:
                        begin
                            // k stays clear until the output sweep
                            k_next     = '0;
                            state_next = ST_IT_RHS_RD;
                        end
                        default: ;
                    endcase
                end
            end
            // search pivot row j >= i with nonzero column i
            ST_NRM_SCAN_RD:
            begin
                rd_addr    = addr_of(j_reg, COL_W'(i_reg));
                state_next = ST_NRM_SCAN_CHK;
            end
            ST_NRM_SCAN_CHK:
            begin
                if (rd_data_reg != '0)
                begin
                    k_next     = '0;
                    state_next = (j_reg == i_reg) ? ST_NRM_PIV_RD : ST_NRM_SWAP_RDI;
                end
                else if (j_reg == n_last)
                    state_next = ST_NRM_FAIL;
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_NRM_SCAN_RD;
                end
            end
            ST_NRM_SWAP_RDI:
            begin
                rd_addr    = addr_of(i_reg, k_reg);
                state_next = ST_NRM_SWAP_RDJ;
            end
            ST_NRM_SWAP_RDJ:
            begin
                t_next     = rd_data_reg;
                rd_addr    = addr_of(j_reg, k_reg);
                state_next = ST_NRM_SWAP_WRI;
            end
            ST_NRM_SWAP_WRI:
            begin
                wr_addr    = addr_of(i_reg, k_reg);
                wr_data    = rd_data_reg;
                wr_en      = 1'b1;
                state_next = ST_NRM_SWAP_WRJ;
            end
            ST_NRM_SWAP_WRJ:
            begin
                wr_addr = addr_of(j_reg, k_reg);
                wr_data = t_reg;
                wr_en   = 1'b1;
                if (k_reg == COL_W'(n_reg))
                begin
                    k_next     = '0;
                    state_next = ST_NRM_PIV_RD;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_NRM_SWAP_RDI;
                end
            end
            ST_NRM_PIV_RD:
            begin
                rd_addr    = addr_of(i_reg, COL_W'(i_reg));
                state_next = ST_NRM_PIV_LATCH;
            end
            ST_NRM_PIV_LATCH:
            begin
                t_next     = rd_data_reg;
                k_next     = '0;
                state_next = ST_NRM_DIV_RD;
            end
            ST_NRM_DIV_RD:
            begin
                rd_addr    = addr_of(i_reg, k_reg);
                state_next = ST_NRM_DIV_START;
            end
            ST_NRM_DIV_START:
            begin
                dreq.start = 1'b1;
                state_next = ST_NRM_DIV_WAIT;
            end
            ST_NRM_DIV_WAIT:
            begin
                if (drsp.done)
                    state_next = ST_NRM_DIV_WR;
            end
            ST_NRM_DIV_WR:
            begin
                wr_addr = addr_of(i_reg, k_reg);
                wr_data = drsp.quot;
                wr_en   = 1'b1;
                if (k_reg == COL_W'(n_reg))
                begin
                    if (i_reg == n_last)
                        state_next = ST_NRM_DONE;
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        j_next     = i_reg + 1'b1;
                        state_next = ST_NRM_SCAN_RD;
                    end
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_NRM_DIV_RD;
                end
            end
            ST_NRM_DONE, ST_NRM_FAIL:
            begin
                // success reports variable 0, failure the row without a pivot
                res_next           = '0;
                res_next.status    = (state_reg == ST_NRM_FAIL);
                res_next.var_index = (state_reg == ST_NRM_FAIL) ? 3'(i_reg) : 3'd0;
                res_next.last      = 1'b1;
                done_next          = 1'b1;
                state_next         = ST_IDLE;
            end
            // iterate: row i
            ST_IT_RHS_RD:
            begin
                rd_addr    = addr_of(i_reg, COL_W'(n_reg));
                state_next = ST_IT_RHS_LATCH;
            end
            ST_IT_RHS_LATCH:
            begin
                g_next  = rd_data_reg;
                jn_next = rd_data_reg;
                j_next  = '0;
                if (n_reg == CNT_W'(1))
                    state_next = ST_IT_ROW_END;
                else if (i_reg == '0)
                begin
                    j_next     = IDX_W'(1);
                    state_next = ST_IT_A_RD;
                end
                else
                    state_next = ST_IT_A_RD;
            end
            ST_IT_A_RD:
            begin
                rd_addr    = addr_of(i_reg, COL_W'(j_reg));
                ph_next    = 1'b0;
                state_next = ST_IT_MUL;
            end
            ST_IT_MUL:
            begin
                a_next     = rd_data_reg;
                state_next = ST_IT_ACC;
            end
            ST_IT_ACC:
            begin
                // phase 0 issues GS product; phase 1 takes it and issues Jacobi
                if (!ph_reg)
                    ph_next = 1'b1;
                else
                begin
                    g_next  = sat_sub(g_reg, mul_p);
                    ph_next = 1'b0;
                    state_next = ST_IT_ROW_END;
                end
            end
            ST_IT_ROW_END:
            begin
                // Jacobi product lands in the cycle after the GS product
                if (n_reg != CNT_W'(1))
                    jn_next = sat_sub(jn_reg, mul_p);
                if (n_reg != CNT_W'(1) && !(j_reg == n_last ||
                    (j_reg + 1'b1 == i_reg && i_reg == n_last)))
                begin
                    j_next     = (j_reg + 1'b1 == i_reg) ? j_reg + IDX_W'(2) : j_reg + 1'b1;
                    state_next = ST_IT_A_RD;
                end
                else
                    state_next = ST_IT_EMIT;
            end
            ST_IT_EMIT:
            begin
                // row done: commit estimates
                gs_wr = 1'b1;
                jn_wr = 1'b1;
                if (i_reg == n_last)
                begin
                    i_next     = '0;
                    state_next = ST_IT_EMIT;
                    k_next     = '0;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_IT_RHS_RD;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
        // output sweep after last row (k_reg marks emit phase)
        if (state_reg == ST_IT_EMIT && i_reg == n_last && k_reg != COL_W'(NCOLS))
            k_next = COL_W'(NCOLS);
        if (state_reg == ST_IT_EMIT && k_reg == COL_W'(NCOLS))
        begin
            gs_wr   = 1'b0;
            jn_wr   = 1'b0;
            emit_wr = 1'b1;
            res_next.status        = 1'b0;
            res_next.var_index     = 3'(i_reg);
            res_next.gs_value      = gs_est_reg[i_reg];
            res_next.gs_change     = sat_sub(gs_est_reg[i_reg], gs_prev_reg[i_reg]);
            res_next.jacobi_value  = jc_next_reg[i_reg];
            res_next.jacobi_change = sat_sub(jc_next_reg[i_reg], jc_est_reg[i_reg]);
            res_next.last          = (i_reg == n_last);
            done_next              = 1'b1;
            k_next                 = COL_W'(NCOLS);
            if (i_reg == n_last)
                state_next = ST_IDLE;
            else
            begin
                i_next     = i_reg + 1'b1;
                state_next = ST_IT_EMIT;
            end
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign res  = res_reg;

endmodule

@@ tb/tb_gauss_seidel_jacobi_solver_unit.sv @@
// Testbench for gauss_seidel_jacobi_solver_unit: directed and random request streams,
// checked against an in-bench fixed-point predictor. Depends on gsj_pkg and the DUT.
`timescale 1ns / 1ps

module tb_gauss_seidel_jacobi_solver_unit;
    import gsj_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    req_beat_t   req = '0;
    logic        busy;
    logic        done;
    res_beat_t   res;

    localparam logic [1:0] EQ_COUNT_ADDR = 2'd0;

    // predictor state
    logic signed [31:0] coef [0:7][0:8];
    logic signed [31:0] gs_est [0:7];
    logic signed [31:0] gs_prev [0:7];
    logic signed [31:0] jac_est [0:7];
    logic signed [31:0] jac_nxt [0:7];
    int unsigned        n_eq;

    res_beat_t pending_results [$];
    int        mismatches = 0;
    int        fails = 0;

    gauss_seidel_jacobi_solver_unit dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .req(req), .busy(busy), .done(done), .res(res)
    );

    always #5 clk = ~clk;

    // ---------------- fixed-point helpers ----------------
    function automatic logic signed [31:0] clamp_mag(logic [63:0] m, bit neg);
        if (neg)
        begin
            if (m > 64'h8000_0000)
                return VMIN;
            return 32'(-longint'(m));
        end
        if (m > 64'h7FFF_FFFF)
            return VMAX;
        return 32'(m);
    endfunction

    function automatic logic [63:0] abs64(logic signed [31:0] a);
        longint t;
        t = a;
        return (t < 0) ? 64'(-t) : 64'(t);
    endfunction

    function automatic logic signed [31:0] q_mul(logic signed [31:0] a, logic signed [31:0] b);
        logic [63:0] p;
        p = abs64(a) * abs64(b);
        return clamp_mag(p >> FRAC_BITS, a[31] ^ b[31]);
    endfunction

    function automatic logic signed [31:0] q_div(logic signed [31:0] a, logic signed [31:0] d);
        logic [63:0] q;
        q = (abs64(a) << FRAC_BITS) / abs64(d);
        return clamp_mag(q, a[31] ^ d[31]);
    endfunction

    function automatic logic signed [31:0] q_sub(logic signed [31:0] a, logic signed [31:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d > 64'sh7FFF_FFFF)
            return VMAX;
        if (d < -64'sh8000_0000)
            return VMIN;
        return 32'(d);
    endfunction

    // ---------------- predictor ----------------
    task automatic predict_beat(req_beat_t b);
        res_beat_t r;
        int unsigned i, j, k;
        logic signed [31:0] t, p, g, jn;
        bit failed;
        r = '0;
        failed = 0;
        case (b.req_type)
            REQ_LOAD_ENTRY:
                if (b.col <= 8)
                    coef[b.row][b.col] = b.value;
            REQ_LOAD_GUESS:
            begin
                gs_est[b.row] = b.value;
                gs_prev[b.row] = b.value;
                jac_est[b.row] = b.value;
            end
            REQ_NORMALIZE:
            begin
                r.last = 1'b1;
                for (i = 0; i < n_eq && !failed; i++)
                begin
                    j = i;
                    while (j < n_eq && coef[j][i] == 0)
                        j++;
                    if (j == n_eq)
                    begin
                        failed = 1;
                        r.status = 1'b1;
                        r.var_index = 3'(i);
                    end
                    else
                    begin
                        for (k = 0; k <= n_eq; k++)
                        begin
                            t = coef[i][k];
                            coef[i][k] = coef[j][k];
                            coef[j][k] = t;
                        end
                        p = coef[i][i];
                        for (k = 0; k <= n_eq; k++)
                            coef[i][k] = q_div(coef[i][k], p);
                    end
                end
                pending_results.push_back(r);
            end
            default:
            begin
                for (i = 0; i < n_eq; i++)
                begin
                    g = coef[i][n_eq];
                    jn = g;
                    for (j = 0; j < n_eq; j++)
                        if (j != i)
                        begin
                            g = q_sub(g, q_mul(coef[i][j], gs_est[j]));
                            jn = q_sub(jn, q_mul(coef[i][j], jac_est[j]));
                        end
                    gs_est[i] = g;
                    jac_nxt[i] = jn;
                end
                for (i = 0; i < n_eq; i++)
                begin
                    r.status = 1'b0;
                    r.var_index = 3'(i);
                    r.gs_value = gs_est[i];
                    r.gs_change = q_sub(gs_est[i], gs_prev[i]);
                    r.jacobi_value = jac_nxt[i];
                    r.jacobi_change = q_sub(jac_nxt[i], jac_est[i]);
                    r.last = (i + 1 == n_eq);
                    gs_prev[i] = gs_est[i];
                    jac_est[i] = jac_nxt[i];
                    pending_results.push_back(r);
                end
            end
        endcase
    endtask

    // ---------------- drivers ----------------
    task automatic send_beat(logic [1:0] kind, int unsigned r, int unsigned c,
                             logic signed [31:0] v);
        int unsigned gap;
        req_beat_t b;
        gap = $urandom_range(0, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        b.req_type = kind;
        b.row = 3'(r);
        b.col = 4'(c);
        b.value = v;
        req <= b;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        predict_beat(b);
    endtask

    // drain: nothing pending and block idle, then a short settle
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_eq_count(logic [31:0] v);
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= EQ_COUNT_ADDR;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        n_eq = (v[3:0] == 0) ? 1 : ((v[3:0] > 8) ? 8 : v[3:0]);
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] small_val();
        return 32'(signed'($urandom_range(0, 32'h8_0000))) - 32'sh4_0000;
    endfunction

    function automatic logic signed [31:0] any_val();
        return ($urandom_range(0, 1) == 1) ? 32'($urandom) : small_val();
    endfunction

    // diagonally dominant system for rows in use, small random guesses
    task automatic load_good_system();
        int unsigned i, k;
        for (i = 0; i < n_eq; i++)
        begin
            for (k = 0; k < n_eq; k++)
                send_beat(REQ_LOAD_ENTRY, i, k,
                          (i == k) ? 32'sh8_0000 + small_val() : small_val() >>> 3);
            send_beat(REQ_LOAD_ENTRY, i, n_eq, small_val());
            send_beat(REQ_LOAD_GUESS, i, $urandom_range(0, 15), small_val() >>> 4);
        end
    endtask

    // ---------------- tests ----------------
    // fill every entry and guess so no read hits an unwritten location
    task automatic test_fill_store();
        int unsigned i, k;
        for (i = 0; i < 8; i++)
        begin
            for (k = 0; k < 9; k++)
                send_beat(REQ_LOAD_ENTRY, i, k, 32'sh1_0000 * (i == k ? 2 : 0) + small_val());
            send_beat(REQ_LOAD_GUESS, i, 0, 32'sh0);
        end
    endtask

    task automatic test_directed();
        write_eq_count(3);
        load_good_system();
        send_beat(REQ_NORMALIZE, 0, 0, 32'sh0);
        send_beat(REQ_ITERATE, 0, 0, 32'sh0);
        send_beat(REQ_ITERATE, 0, 0, 32'sh0);
        // field extremes and ignored column loads
        send_beat(REQ_LOAD_ENTRY, 0, 1, VMAX);
        send_beat(REQ_LOAD_ENTRY, 1, 0, VMIN);
        send_beat(REQ_LOAD_ENTRY, 7, 15, VMAX);
        send_beat(REQ_LOAD_GUESS, 2, 9, VMIN);
        send_beat(REQ_ITERATE, 0, 0, 32'sh0);
        // no usable pivot in column one
        send_beat(REQ_LOAD_ENTRY, 0, 1, 32'sh0);
        send_beat(REQ_LOAD_ENTRY, 1, 1, 32'sh0);
        send_beat(REQ_LOAD_ENTRY, 2, 1, 32'sh0);
        send_beat(REQ_NORMALIZE, 0, 0, 32'sh0);
        // zero pivot on row zero forces a swap
        send_beat(REQ_LOAD_ENTRY, 0, 0, 32'sh0);
        send_beat(REQ_LOAD_ENTRY, 2, 1, 32'sh3_0000);
        send_beat(REQ_NORMALIZE, 0, 0, 32'sh0);
        // eq_count 0 acts as 1, above 8 acts as 8
        write_eq_count(0);
        send_beat(REQ_ITERATE, 0, 0, 32'sh0);
        write_eq_count(15);
        send_beat(REQ_ITERATE, 0, 0, 32'sh0);
    endtask

    task automatic test_random(int unsigned items);
        int unsigned sent, k, reps, kind;
        logic [31:0] settings [0:5];
        settings = '{32'd8, 32'd1, 32'd5, 32'd2, 32'd12, 32'd4};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_eq_count(settings[ph]);
            sent = 0;
            while (sent < items / 6)
            begin
                if ($urandom_range(0, 9) < 6)
                begin
                    load_good_system();
                    sent += n_eq * (n_eq + 2);
                    if ($urandom_range(0, 2) == 0)
                    begin
                        send_beat(REQ_NORMALIZE, 0, 0, any_val());
                        sent++;
                    end
                    reps = $urandom_range(1, 4);
                    for (k = 0; k < reps; k++)
                        send_beat(REQ_ITERATE, $urandom_range(0, 7), $urandom_range(0, 15),
                                  any_val());
                    sent += reps;
                end
                else
                begin
                    for (k = 0; k < 5; k++)
                    begin
                        kind = $urandom_range(0, 9);
                        send_beat(kind < 5 ? REQ_LOAD_ENTRY : kind < 7 ? REQ_LOAD_GUESS :
                                  kind < 8 ? REQ_NORMALIZE : REQ_ITERATE,
                                  $urandom_range(0, 7), $urandom_range(0, 15), any_val());
                    end
                    sent += 5;
                end
            end
        end
    endtask

    // ---------------- result checker ----------------
    always @(posedge clk)
    begin
        res_beat_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                fails++;
                $display("unexpected result beat: var %0d", res.var_index);
            end
            else
            begin
                want = pending_results.pop_front();
                if (res.status !== want.status || res.var_index !== want.var_index ||
                    res.gs_value !== want.gs_value || res.gs_change !== want.gs_change ||
                    res.jacobi_value !== want.jacobi_value ||
                    res.jacobi_change !== want.jacobi_change || res.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp st=%0d idx=%0d gs=%h/%h jac=%h/%h last=%0d | act st=%0d idx=%0d gs=%h/%h jac=%h/%h last=%0d",
                                 want.status, want.var_index, want.gs_value, want.gs_change,
                                 want.jacobi_value, want.jacobi_change, want.last,
                                 res.status, res.var_index, res.gs_value, res.gs_change,
                                 res.jacobi_value, res.jacobi_change, res.last);
                end
            end
        end
    end

    // ---------------- sequence ----------------
    initial
    begin
        n_eq = 8;
        for (int i = 0; i < 8; i++)
        begin
            gs_est[i] = '0;
            gs_prev[i] = '0;
            jac_est[i] = '0;
            jac_nxt[i] = '0;
            for (int k = 0; k < 9; k++)
                coef[i][k] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_store();
        test_directed();
        test_random(240);
        wait_idle();
        repeat (300) @(posedge clk);
        if (mismatches == 0 && fails == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/gsj_pkg.sv
hdl/gsj_div.sv
hdl/gsj_mul.sv
hdl/gauss_seidel_jacobi_solver_unit.sv
tb/tb_gauss_seidel_jacobi_solver_unit.sv
